// ===== rtl/assert_macros.svh =====
// Assertion macros used by the camera_ray_direction RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define CRD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define CRD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CRD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CRD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/crd_pkg.sv =====
// Shared constants and types of the camera ray direction block.
package crd_pkg;

  localparam int COMPONENT_WIDTH_DEF = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_Z      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TAN_FOV   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ASPECT    = 3'd7;

  localparam int SCALE_W   = 16;  // tan and aspect, unsigned Q4.12
  localparam int TA_FRAC   = 12;
  localparam int NORM_BITS = 30;  // normalized magnitudes, top at bit 29
  localparam int ROOT_W    = 31;
  localparam int SUM_W     = 2 * ROOT_W;

  typedef struct packed {
    logic       zero;
    logic [2:0] neg;
  } crd_flags_t;

endpackage

// ===== rtl/crd_ray_in_if.sv =====
// Screen coordinate channel.
interface crd_ray_in_if #(
  parameter int COMPONENT_WIDTH = crd_pkg::COMPONENT_WIDTH_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic signed [COMPONENT_WIDTH-1:0] screen_u;
  logic signed [COMPONENT_WIDTH-1:0] screen_v;

  modport source (output valid, screen_u, screen_v, input ready);
  modport sink (input valid, screen_u, screen_v, output ready);
endinterface

// ===== rtl/crd_ray_out_if.sv =====
// Ray direction channel.
interface crd_ray_out_if #(
  parameter int COMPONENT_WIDTH = crd_pkg::COMPONENT_WIDTH_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic signed [COMPONENT_WIDTH-1:0] dir_x;
  logic signed [COMPONENT_WIDTH-1:0] dir_y;
  logic signed [COMPONENT_WIDTH-1:0] dir_z;
  logic                              degenerate;

  modport source (output valid, dir_x, dir_y, dir_z, degenerate, input ready);
  modport sink (input valid, dir_x, dir_y, dir_z, degenerate, output ready);
endinterface

// ===== rtl/camera_ray_direction.sv =====
// Pinhole camera ray generation: screen coordinate in, unit ray direction out.
//
// One screen coordinate (u, v) is taken per clock while input ready is high,
// and one unit direction comes out per coordinate, in order. The pipeline is
// 9 arithmetic stages (cross products, scales, direction sum, magnitude,
// leading-one search, normalizing shift, squares, sum), then 31 square-root
// stages (one root bit each), then COMPONENT_WIDTH-1 divider stages (one
// quotient bit each), then the output register. Throughput is one ray per
// clock while input ready is high. An output register backed by a one-entry
// skid stage keeps input ready high while a result waits; ready drops only
// once the skid entry holds a result. Write the configuration registers only
// while no ray is in flight. A zero-length direction returns zero components
// with degenerate set.
`include "assert_macros.svh"

module camera_ray_direction #(
  parameter int COMPONENT_WIDTH = crd_pkg::COMPONENT_WIDTH_DEF,
  localparam int CfgW = (COMPONENT_WIDTH > crd_pkg::SCALE_W) ?
                        COMPONENT_WIDTH : crd_pkg::SCALE_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [crd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]               cfg_wdata_i,
  crd_ray_in_if.sink                    ray_in_i,
  crd_ray_out_if.source                 ray_out_o
);
  import crd_pkg::*;

  localparam int W   = COMPONENT_WIDTH;
  localparam int F   = W - 2;
  localparam int PW  = 2 * W;
  localparam int XW  = W + 3;
  localparam int SVW = SCALE_W + 1 + W - F;
  localparam int TAW = 2 * SCALE_W - TA_FRAC;
  localparam int SUW = TAW + 1 + W - F;
  localparam int DW  = W + 24;
  localparam int PSW = $clog2(DW);
  localparam int QW  = W - 1;
  localparam int SQW = 2 * NORM_BITS;

  localparam logic signed [XW-1:0] CompMax = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] CompMin = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [W-1:0]  OneComp = {2'b01, {F{1'b0}}};
  localparam logic signed [W-1:0]  NegOne  = -OneComp;
  localparam logic [PSW-1:0]       TopPos  = PSW'(NORM_BITS - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [W-1:0]  fwd_q [3];
  logic signed [W-1:0]  up_q  [3];
  logic [SCALE_W-1:0]   tan_q;
  logic [SCALE_W-1:0]   asp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q[0] <= '0;
      fwd_q[1] <= '0;
      fwd_q[2] <= OneComp;
      up_q[0]  <= '0;
      up_q[1]  <= OneComp;
      up_q[2]  <= '0;
      tan_q    <= SCALE_W'(1 << TA_FRAC);
      asp_q    <= SCALE_W'(1 << TA_FRAC);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FORWARD_X: fwd_q[0] <= cfg_wdata_i[W-1:0];
        CFG_FORWARD_Y: fwd_q[1] <= cfg_wdata_i[W-1:0];
        CFG_FORWARD_Z: fwd_q[2] <= cfg_wdata_i[W-1:0];
        CFG_UP_X:      up_q[0]  <= cfg_wdata_i[W-1:0];
        CFG_UP_Y:      up_q[1]  <= cfg_wdata_i[W-1:0];
        CFG_UP_Z:      up_q[2]  <= cfg_wdata_i[W-1:0];
        CFG_TAN_FOV:   tan_q    <= cfg_wdata_i[SCALE_W-1:0];
        CFG_ASPECT:    asp_q    <= cfg_wdata_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // One saturated cross-product term: floor(a*b/2^F) - floor(c*d/2^F)
  function automatic logic signed [W-1:0] xterm(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b,
                                                input logic signed [W-1:0] c,
                                                input logic signed [W-1:0] d);
    logic signed [PW-1:0] p0;
    logic signed [PW-1:0] p1;
    logic signed [XW-1:0] s;
    p0 = a * b;
    p1 = c * d;
    s  = XW'(p0 >>> F) - XW'(p1 >>> F);
    if (s > CompMax) begin
      return CompMax[W-1:0];
    end else if (s < CompMin) begin
      return CompMin[W-1:0];
    end
    return s[W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Pipeline control: all stages advance together unless the skid is full
  // ---------------------------------------------------------------------------
  logic en;
  logic in_fire;
  logic skid_valid_q;
  logic out_valid_q;

  assign en             = !skid_valid_q;
  assign ray_in_i.ready = en;
  assign in_fire        = ray_in_i.valid && en;

  // Stage 1: right vector, v scale, tan*aspect
  logic                  v1_q;
  logic signed [W-1:0]   r1_q [3];
  logic signed [SVW-1:0] sv1_q;
  logic [TAW-1:0]        ta1_q;
  logic signed [W-1:0]   u1_q;
  logic signed [W-1:0]   r1_d [3];
  logic signed [SVW+F-1:0] tv_prod;
  logic [2*SCALE_W-1:0]  ta_prod;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r1_d[i] = xterm(fwd_q[(i + 1) % 3], up_q[(i + 2) % 3],
                      fwd_q[(i + 2) % 3], up_q[(i + 1) % 3]);
    end
    tv_prod = $signed({1'b0, tan_q}) * ray_in_i.screen_v;
    ta_prod = tan_q * asp_q;
  end

  // Stage 2: corrected up vector, u scale
  logic                  v2_q;
  logic signed [W-1:0]   r2_q [3];
  logic signed [W-1:0]   q2_q [3];
  logic signed [SVW-1:0] sv2_q;
  logic signed [SUW-1:0] su2_q;
  logic signed [W-1:0]   q2_d [3];
  logic signed [SUW+F-1:0] tu_prod;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q2_d[i] = xterm(r1_q[(i + 1) % 3], fwd_q[(i + 2) % 3],
                      r1_q[(i + 2) % 3], fwd_q[(i + 1) % 3]);
    end
    tu_prod = $signed({1'b0, ta1_q}) * u1_q;
  end

  // Stage 3: scaled basis products
  logic                    v3_q;
  logic signed [SVW+W-1:0] pq3_q [3];
  logic signed [SUW+W-1:0] pr3_q [3];

  // Stage 4: direction sum
  logic                  v4_q;
  logic signed [DW-1:0]  d4_q [3];
  logic signed [DW-1:0]  d4_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d4_d[i] = (DW'(fwd_q[i]) <<< TA_FRAC) + DW'(pq3_q[i]) + DW'(pr3_q[i]);
    end
  end

  // Stage 5: magnitudes, largest, zero detect
  logic                  v5_q;
  logic [DW-1:0]         m5_q [3];
  logic [DW-1:0]         mx5_q;
  crd_flags_t            fl5_q;
  logic [DW-1:0]         m5_d [3];
  logic [DW-1:0]         mx5_d;
  logic [2:0]            neg5_d;

  always_comb begin
    mx5_d = '0;
    for (int i = 0; i < 3; i++) begin
      neg5_d[i] = d4_q[i][DW-1];
      m5_d[i]   = neg5_d[i] ? DW'(-d4_q[i]) : DW'(d4_q[i]);
      if (m5_d[i] > mx5_d) begin
        mx5_d = m5_d[i];
      end
    end
  end

  // Stage 6: leading-one position of the largest magnitude
  logic                  v6_q;
  logic [DW-1:0]         m6_q [3];
  logic [PSW-1:0]        lead6_q;
  crd_flags_t            fl6_q;
  logic [PSW-1:0]        lead6_d;

  always_comb begin
    lead6_d = '0;
    for (int b = 0; b < DW; b++) begin
      if (mx5_q[b]) begin
        lead6_d = PSW'(b);
      end
    end
  end

  // Stage 7: common shift putting the largest at bit NORM_BITS-1
  logic                  v7_q;
  logic [NORM_BITS-1:0]  n7_q [3];
  crd_flags_t            fl7_q;
  logic [NORM_BITS-1:0]  n7_d [3];
  logic [DW-1:0]         sh7;

  always_comb begin
    sh7 = '0;
    for (int i = 0; i < 3; i++) begin
      if (lead6_q > TopPos) begin
        sh7 = m6_q[i] >> (lead6_q - TopPos);
      end else begin
        sh7 = m6_q[i] << (TopPos - lead6_q);
      end
      n7_d[i] = sh7[NORM_BITS-1:0];
    end
  end

  // Stage 8: squares; stage 9: sum of squares
  logic                  v8_q;
  logic [SQW-1:0]        sq8_q [3];
  logic [NORM_BITS-1:0]  n8_q  [3];
  crd_flags_t            fl8_q;

  logic                  v9_q;
  logic [SUM_W-1:0]      sum9_q;
  logic [NORM_BITS-1:0]  n9_q  [3];
  crd_flags_t            fl9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_fire;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_q  <= r1_d;
      sv1_q <= SVW'(tv_prod >>> F);
      ta1_q <= ta_prod[2*SCALE_W-1:TA_FRAC];
      u1_q  <= ray_in_i.screen_u;

      r2_q  <= r1_q;
      q2_q  <= q2_d;
      sv2_q <= sv1_q;
      su2_q <= SUW'(tu_prod >>> F);

      for (int i = 0; i < 3; i++) begin
        pq3_q[i] <= sv2_q * q2_q[i];
        pr3_q[i] <= su2_q * r2_q[i];
      end

      d4_q <= d4_d;

      m5_q       <= m5_d;
      mx5_q      <= mx5_d;
      fl5_q.zero <= (mx5_d == '0);
      fl5_q.neg  <= neg5_d;

      m6_q    <= m5_q;
      lead6_q <= lead6_d;
      fl6_q   <= fl5_q;

      n7_q  <= n7_d;
      fl7_q <= fl6_q;

      for (int i = 0; i < 3; i++) begin
        sq8_q[i] <= n7_q[i] * n7_q[i];
      end
      n8_q  <= n7_q;
      fl8_q <= fl7_q;

      sum9_q <= SUM_W'(sq8_q[0]) + SUM_W'(sq8_q[1]) + SUM_W'(sq8_q[2]);
      n9_q   <= n8_q;
      fl9_q  <= fl8_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Length and division
  // ---------------------------------------------------------------------------
  logic                 sq_valid;
  logic [ROOT_W-1:0]    sq_root;
  logic [NORM_BITS-1:0] sq_mag [3];
  crd_flags_t           sq_flags;

  crd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v9_q),
    .sum_i   (sum9_q),
    .mag_i   (n9_q),
    .flags_i (fl9_q),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .mag_o   (sq_mag),
    .flags_o (sq_flags)
  );

  logic        dv_valid;
  logic [QW-1:0] dv_quot [3];
  crd_flags_t  dv_flags;

  crd_div #(
    .QW (QW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .mag_i   (sq_mag),
    .root_i  (sq_root),
    .flags_i (sq_flags),
    .valid_o (dv_valid),
    .quot_o  (dv_quot),
    .flags_o (dv_flags)
  );

  // ---------------------------------------------------------------------------
  // Sign, degenerate case, output register and skid stage
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] res_dir [3];
  logic [W-1:0]        q_ext;
  logic                push;
  logic                pop;

  always_comb begin
    q_ext = '0;
    for (int i = 0; i < 3; i++) begin
      q_ext = W'(dv_quot[i]);
      if (dv_flags.zero) begin
        res_dir[i] = '0;
      end else begin
        res_dir[i] = dv_flags.neg[i] ? -q_ext : q_ext;
      end
    end
  end

  assign push = en && dv_valid;
  assign pop  = out_valid_q && ray_out_o.ready;

  logic signed [W-1:0] out_dir_q  [3];
  logic                out_deg_q;
  logic signed [W-1:0] skid_dir_q [3];
  logic                skid_deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      // drain the skid first; a push cannot land while it is full
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_dir_q <= skid_dir_q;
        out_deg_q <= skid_deg_q;
      end else begin
        out_dir_q <= res_dir;
        out_deg_q <= dv_flags.zero;
      end
    end else if (push) begin
      skid_dir_q <= res_dir;
      skid_deg_q <= dv_flags.zero;
    end
  end

  assign ray_out_o.valid      = out_valid_q;
  assign ray_out_o.dir_x      = out_dir_q[0];
  assign ray_out_o.dir_y      = out_dir_q[1];
  assign ray_out_o.dir_z      = out_dir_q[2];
  assign ray_out_o.degenerate = out_deg_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `CRD_ASSERT_IMP(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `CRD_ASSERT_NXT(a_accept_enters, clk_i, rst_ni, in_fire, v1_q)
  `CRD_ASSERT_IMP(a_degen_zero, clk_i, rst_ni, out_valid_q && out_deg_q,
                  (out_dir_q[0] == '0) && (out_dir_q[1] == '0) &&
                  (out_dir_q[2] == '0))
  `CRD_ASSERT_IMP(a_dir_unit_range, clk_i, rst_ni, out_valid_q,
                  (out_dir_q[0] <= OneComp) && (out_dir_q[0] >= NegOne) &&
                  (out_dir_q[1] <= OneComp) && (out_dir_q[1] >= NegOne) &&
                  (out_dir_q[2] <= OneComp) && (out_dir_q[2] >= NegOne))

endmodule

// ===== rtl/crd_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, with sideband.
module crd_isqrt (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [crd_pkg::SUM_W-1:0]           sum_i,
  input  logic [crd_pkg::NORM_BITS-1:0]       mag_i [3],
  input  crd_pkg::crd_flags_t                 flags_i,
  output logic                                valid_o,
  output logic [crd_pkg::ROOT_W-1:0]          root_o,
  output logic [crd_pkg::NORM_BITS-1:0]       mag_o [3],
  output crd_pkg::crd_flags_t                 flags_o
);
  import crd_pkg::*;

  localparam int RW = ROOT_W + 2;

  logic                 v_q    [ROOT_W];
  logic [SUM_W-1:0]     x_q    [ROOT_W];
  logic [ROOT_W-1:0]    root_q [ROOT_W];
  logic [RW-1:0]        rem_q  [ROOT_W];
  logic [NORM_BITS-1:0] mag_q  [ROOT_W][3];
  crd_flags_t           fl_q   [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_st
    localparam int I = ROOT_W - 1 - s;
    logic                 v_in;
    logic [SUM_W-1:0]     x_in;
    logic [ROOT_W-1:0]    root_in;
    logic [RW-1:0]        rem_in;
    logic [NORM_BITS-1:0] mag_in [3];
    crd_flags_t           fl_in;
    logic [RW-1:0]        rem_sh;
    logic [RW-1:0]        trial;
    logic                 take;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign x_in    = sum_i;
      assign root_in = '0;
      assign rem_in  = '0;
      assign mag_in  = mag_i;
      assign fl_in   = flags_i;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign x_in    = x_q[s-1];
      assign root_in = root_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign mag_in  = mag_q[s-1];
      assign fl_in   = fl_q[s-1];
    end

    always_comb begin
      rem_sh = {rem_in[ROOT_W-1:0], x_in[2*I+1:2*I]};
      trial  = {root_in, 2'b01};
      take   = (rem_sh >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[s]    <= x_in;
        root_q[s] <= {root_in[ROOT_W-2:0], take};
        rem_q[s]  <= take ? (rem_sh - trial) : rem_sh;
        mag_q[s]  <= mag_in;
        fl_q[s]   <= fl_in;
      end
    end
  end

  assign valid_o = v_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign mag_o   = mag_q[ROOT_W-1];
  assign flags_o = fl_q[ROOT_W-1];

endmodule

// ===== rtl/crd_div.sv =====
// Pipelined three-lane restoring divider, one quotient bit per stage.
module crd_div #(
  parameter int QW = crd_pkg::COMPONENT_WIDTH_DEF - 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [crd_pkg::NORM_BITS-1:0] mag_i [3],
  input  logic [crd_pkg::ROOT_W-1:0]    root_i,
  input  crd_pkg::crd_flags_t           flags_i,
  output logic                          valid_o,
  output logic [QW-1:0]                 quot_o [3],
  output crd_pkg::crd_flags_t           flags_o
);
  import crd_pkg::*;

  localparam int NW = NORM_BITS + QW;

  logic [NW-1:0] num0 [3];

  // Numerator is m * 2^F + floor(L/2), with F = QW - 1
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      num0[l] = (NW'(mag_i[l]) << (QW - 1)) + NW'(root_i >> 1);
    end
  end

  logic              v_q   [QW];
  logic [NW-1:0]     n_q   [QW][3];
  logic [ROOT_W-1:0] rem_q [QW][3];
  logic [QW-1:0]     q_q   [QW][3];
  logic [ROOT_W-1:0] den_q [QW];
  crd_flags_t        fl_q  [QW];

  for (genvar s = 0; s < QW; s++) begin : g_st
    localparam int I = QW - 1 - s;
    logic              v_in;
    logic [NW-1:0]     n_in   [3];
    logic [ROOT_W-1:0] rem_in [3];
    logic [QW-1:0]     q_in   [3];
    logic [ROOT_W-1:0] den_in;
    crd_flags_t        fl_in;
    logic [ROOT_W:0]   rem_sh [3];
    logic [ROOT_W-1:0] rem_nx [3];
    logic [QW-1:0]     q_nx   [3];

    if (s == 0) begin : g_first
      assign v_in   = valid_i;
      assign n_in   = num0;
      assign den_in = root_i;
      assign fl_in  = flags_i;
      for (genvar l = 0; l < 3; l++) begin : g_ln
        assign rem_in[l] = ROOT_W'(num0[l][NW-1:QW]);
        assign q_in[l]   = '0;
      end
    end else begin : g_next
      assign v_in   = v_q[s-1];
      assign n_in   = n_q[s-1];
      assign rem_in = rem_q[s-1];
      assign q_in   = q_q[s-1];
      assign den_in = den_q[s-1];
      assign fl_in  = fl_q[s-1];
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        rem_sh[l] = {rem_in[l], n_in[l][I]};
        if (rem_sh[l] >= {1'b0, den_in}) begin
          rem_nx[l] = ROOT_W'(rem_sh[l] - {1'b0, den_in});
          q_nx[l]   = {q_in[l][QW-2:0], 1'b1};
        end else begin
          rem_nx[l] = rem_sh[l][ROOT_W-1:0];
          q_nx[l]   = {q_in[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[s]   <= n_in;
        rem_q[s] <= rem_nx;
        q_q[s]   <= q_nx;
        den_q[s] <= den_in;
        fl_q[s]  <= fl_in;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quot_o  = q_q[QW-1];
  assign flags_o = fl_q[QW-1];

endmodule
